FILE: sv/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and tables for the epoch-to-calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    localparam int SEC_PER_DAY  = 24 * 60 * 60;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;
    localparam int FIRST_YEAR   = 1970;
    localparam int DAYS_YEAR    = 365;
    localparam int DAYS_LEAP    = 366;
    localparam int FEB_LEAP     = 29;

    // Division by constant: the divisor's power of two is dropped from the
    // dividend, the odd part d is handled as (x * ceil(2^k / d)) >> k, which
    // is exact over each dividend's range.
    //   86400 = 675 << 7, k = 35;  3600 = 225 << 4, k = 21;  60 = 15 << 2, k = 14
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    localparam int LAST_MONTH = 11;

    localparam logic [11:0] YEAR_INIT   = 12'(FIRST_YEAR);
    localparam logic [1:0]  YEAR_MOD4   = 2'(FIRST_YEAR % 4);
    localparam logic [6:0]  YEAR_MOD100 = 7'(FIRST_YEAR % 100);
    localparam logic [8:0]  YEAR_MOD400 = 9'(FIRST_YEAR % 400);

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DAY,
        DP_TOD,
        DP_HOUR,
        DP_HREM,
        DP_MIN,
        DP_YEAR_INIT,
        DP_YEAR_STEP,
        DP_MONTH_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } dp_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAY,
        S_TOD,
        S_HOUR,
        S_HREM,
        S_MIN,
        S_LD_YEAR,
        S_YEAR,
        S_MONTH,
        S_DONE
    } state_t;

    // Month length, month index 0 = January
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                4'd0:    len = 5'd31;
                4'd1:    len = leap ? 5'(FEB_LEAP) : 5'd28;
                4'd2:    len = 5'd31;
                4'd3:    len = 5'd30;
                4'd4:    len = 5'd31;
                4'd5:    len = 5'd30;
                4'd6:    len = 5'd31;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd30;
                4'd9:    len = 5'd31;
                4'd10:   len = 5'd30;
                4'd11:   len = 5'd31;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts unsigned seconds since 1970-01-01 00:00:00 to Gregorian date
// and time of day.
//
//   channel   handshake          fields
//   -------   ---------          ------
//   command   start / busy       epoch_seconds
//   result    done (1 cycle)     hour, minute, second, day_of_month,
//                                month_number, year_number
//
// A word is taken when start is high and busy is low. The fixed steps
// S_DAY through S_LD_YEAR then run the reciprocal-multiply divisions; the
// year walk (one year per cycle) follows for Y = years past 1970 (0..136),
// then the month walk for M = month index (0..11); the range tops out in
// February 2106. The year walk dominates. busy drops the cycle after done,
// so a new word is taken only once the previous result is out.
// Result ports are valid only while done is high; there is no stall.
// Asynchronous reset returns the controller to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar
    import esc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] epoch_seconds,
    output logic             done,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second,
    output logic [4:0]       day_of_month,
    output logic [3:0]       month_number,
    output logic [11:0]      year_number
);

    dp_cmd_t    cmd;
    dp_status_t status;

    esc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    esc_dp u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .epoch_seconds (epoch_seconds),
        .status        (status),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .day_of_month  (day_of_month),
        .month_number  (month_number),
        .year_number   (year_number)
    );

endmodule

`default_nettype wire

FILE: sv/esc_dp.sv
// ----------------------------------------------------------------------------
// esc_dp
// Datapath: reciprocal-multiply division by constant (day, hour, minute),
// year walk with modular leap counters, month walk, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_dp
    import esc_pkg::*;
(
    input  wire logic        clk,
    input  wire dp_cmd_t     cmd,
    input  wire logic [31:0] epoch_seconds,
    output dp_status_t       status,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second,
    output logic [4:0]       day_of_month,
    output logic [3:0]       month_number,
    output logic [11:0]      year_number
);

    logic [31:0] secs_reg, secs_next;
    logic [15:0] days_reg, days_next;
    logic [16:0] tod_reg, tod_next;
    logic [4:0]  hour_reg, hour_next;
    logic [11:0] rem_reg, rem_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [11:0] year_reg, year_next;
    logic [1:0]  mod4_reg, mod4_next;
    logic [6:0]  mod100_reg, mod100_next;
    logic [8:0]  mod400_reg, mod400_next;
    logic [3:0]  month_reg, month_next;

    logic [50:0] day_prod;
    logic [31:0] day_secs;
    logic [26:0] hour_prod;
    logic [16:0] hour_secs;
    logic [20:0] min_prod;
    logic [11:0] min_secs;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    // quotients: bits [50:35], [25:21], [19:14]; remainders by back-multiply
    assign day_prod  = 51'(secs_reg[31:7]) * 51'(DAY_RECIP);
    assign day_secs  = 32'(days_reg) * 32'(SEC_PER_DAY);
    assign hour_prod = 27'(tod_reg[16:4]) * 27'(HOUR_RECIP);
    assign hour_secs = 17'(hour_reg) * 17'(SEC_PER_HOUR);
    assign min_prod  = 21'(rem_reg[11:2]) * 21'(MIN_RECIP);
    assign min_secs  = 12'(minute_reg) * 12'(SEC_PER_MIN);

    assign leap = (mod4_reg == 2'd0) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));
    assign ylen = leap ? 9'(DAYS_LEAP) : 9'(DAYS_YEAR);
    assign mlen = month_len(month_reg, leap);

    assign status.year_done  = (days_reg < 16'(ylen));
    assign status.month_done = (month_reg == 4'(LAST_MONTH)) || (days_reg < 16'(mlen));

    always_comb
    begin
        secs_next   = secs_reg;
        days_next   = days_reg;
        tod_next    = tod_reg;
        hour_next   = hour_reg;
        rem_next    = rem_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        year_next   = year_reg;
        mod4_next   = mod4_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        month_next  = month_reg;
        case (cmd.op)
            DP_NOP:
            begin
            end
            DP_LOAD:
            begin
                secs_next = epoch_seconds;
            end
            DP_DAY:
            begin
                days_next = day_prod[50:35];
            end
            DP_TOD:
            begin
                tod_next = 17'(secs_reg - day_secs);
            end
            DP_HOUR:
            begin
                hour_next = hour_prod[25:21];
            end
            DP_HREM:
            begin
                rem_next = 12'(tod_reg - hour_secs);
            end
            DP_MIN:
            begin
                minute_next = min_prod[19:14];
            end
            DP_YEAR_INIT:
            begin
                second_next = 6'(rem_reg - min_secs);
                year_next   = YEAR_INIT;
                mod4_next   = YEAR_MOD4;
                mod100_next = YEAR_MOD100;
                mod400_next = YEAR_MOD400;
                month_next  = '0;
            end
            DP_YEAR_STEP:
            begin
                days_next   = days_reg - 16'(ylen);
                year_next   = year_reg + 12'd1;
                mod4_next   = mod4_reg + 2'd1;
                mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
            end
            DP_MONTH_STEP:
            begin
                days_next  = days_reg - 16'(mlen);
                month_next = month_reg + 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        secs_reg   <= secs_next;
        days_reg   <= days_next;
        tod_reg    <= tod_next;
        hour_reg   <= hour_next;
        rem_reg    <= rem_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        year_reg   <= year_next;
        mod4_reg   <= mod4_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        month_reg  <= month_next;
    end

    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign day_of_month = days_reg[4:0] + 5'd1;
    assign month_number = month_reg + 4'd1;
    assign year_number  = year_reg;

endmodule

`default_nettype wire

FILE: sv/esc_ctrl.sv
// ----------------------------------------------------------------------------
// esc_ctrl
// Controller: sequences the division steps, the year walk and the month walk.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ctrl
    import esc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            busy,
    output logic            done
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DAY;
                end
            end
            S_DAY:
            begin
                cmd.op     = DP_DAY;
                state_next = S_TOD;
            end
            S_TOD:
            begin
                cmd.op     = DP_TOD;
                state_next = S_HOUR;
            end
            S_HOUR:
            begin
                cmd.op     = DP_HOUR;
                state_next = S_HREM;
            end
            S_HREM:
            begin
                cmd.op     = DP_HREM;
                state_next = S_MIN;
            end
            S_MIN:
            begin
                cmd.op     = DP_MIN;
                state_next = S_LD_YEAR;
            end
            S_LD_YEAR:
            begin
                cmd.op     = DP_YEAR_INIT;
                state_next = S_YEAR;
            end
            S_YEAR:
            begin
                if (status.year_done)
                    state_next = S_MONTH;
                else
                    cmd.op = DP_YEAR_STEP;
            end
            S_MONTH:
            begin
                if (status.month_done)
                    state_next = S_DONE;
                else
                    cmd.op = DP_MONTH_STEP;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
